>>> src/rational_arith_unit_macros.svh
// Assertion macros for the rational arithmetic unit.
// Used by the front and back modules; no other dependencies.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RAU_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rst_n, prop, msg)
`define RAU_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
	localparam int WIDTH = 32;
	localparam int MW = 2 * WIDTH;

	localparam logic [2:0] FUNC_ADD = 3'd0;
	localparam logic [2:0] FUNC_SUB = 3'd1;
	localparam logic [2:0] FUNC_MUL = 3'd2;
	localparam logic [2:0] FUNC_DIV = 3'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;

	typedef struct packed {
		logic [2:0] func;
		logic signed [31:0] lhs_num;
		logic signed [31:0] lhs_den;
		logic signed [31:0] rhs_num;
		logic signed [31:0] rhs_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0] res_den;
		logic [1:0] status;
	} out_item_t;

	// Classified item handed from front to back.
	typedef struct packed {
		logic [1:0] status;    // nonzero: error, no computation
		logic [2:0] op;        // ADD/SUB/MUL/DIV, anything else reduce
		logic ln_neg, ld_neg, rn_neg, rd_neg;
		logic [WIDTH-1:0] ln, ld, rn, rd;   // magnitudes
	} cls_t;

	typedef enum logic [2:0] {
		B_IDLE, B_MUL, B_GCD, B_DIVN, B_DIVD, B_DONE
	} back_state_t;
endpackage

>>> src/rational_arith_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide or reduce fractions.
// Depends on rau_pkg, rau_front and rau_back.
//
// Input channel in_valid/in_ready carries in_data (func and two fractions);
// output channel out_valid/out_ready carries out_data (reduced fraction and
// status). Each input transfer yields exactly one output transfer, in order.
// The front classifies an item in its accept cycle and queues it (two entries);
// the back forms cross products on one 32x32 multiplier in sequence,
// runs Euclid with a one-bit-per-cycle shift-subtract divider, one
// division per remainder step, then divides numerator and denominator by
// the GCD, one after the other. There is always at least one Euclid step;
// error items skip the Euclid and division steps. The back holds one item
// at a time: it takes a new item only after the last result has been loaded
// into the output register. The result sits there; while the receiver stalls
// it holds, the back waits, and the front keeps taking items until its queue
// is full. Reset clears the queue and the back sequencer; no results are
// pending after reset.
module rational_arith_unit import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic cls_valid, cls_ready;
	cls_t cls_data;

	rau_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cls_valid(cls_valid), .cls_ready(cls_ready), .cls_data(cls_data)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cls_valid(cls_valid), .cls_ready(cls_ready), .cls_data(cls_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

>>> src/rau_front.sv
// Front part: takes input items, takes magnitudes and signs, checks errors.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     cls_valid,
	input  logic     cls_ready,
	output cls_t     cls_data
);
	`include "rational_arith_unit_macros.svh"

	logic [WIDTH-1:0] ln, ld, rn, rd;
	logic lnn, ldn, rnn, rdn, two;
	cls_t c;

	assign lnn = in_data.lhs_num[WIDTH-1];
	assign ldn = in_data.lhs_den[WIDTH-1];
	assign rnn = in_data.rhs_num[WIDTH-1];
	assign rdn = in_data.rhs_den[WIDTH-1];
	assign ln = lnn ? (~in_data.lhs_num[WIDTH-1:0] + 1'b1) : in_data.lhs_num[WIDTH-1:0];
	assign ld = ldn ? (~in_data.lhs_den[WIDTH-1:0] + 1'b1) : in_data.lhs_den[WIDTH-1:0];
	assign rn = rnn ? (~in_data.rhs_num[WIDTH-1:0] + 1'b1) : in_data.rhs_num[WIDTH-1:0];
	assign rd = rdn ? (~in_data.rhs_den[WIDTH-1:0] + 1'b1) : in_data.rhs_den[WIDTH-1:0];
	assign two = (in_data.func <= FUNC_DIV);

	always_comb begin
		c = '0;
		c.op = in_data.func;
		c.ln_neg = lnn;
		c.ld_neg = ldn;
		c.rn_neg = rnn;
		c.rd_neg = rdn;
		c.ln = ln;
		c.ld = ld;
		c.rn = rn;
		c.rd = rd;
		if (ld == '0 || (two && rd == '0)) begin
			c.status = ST_ZDEN;
		end else if (in_data.func == FUNC_DIV && rn == '0) begin
			c.status = ST_DIVZ;
		end else begin
			c.status = ST_OK;
		end
	end

	// Two-entry queue toward the back part.
	cls_t q_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = cls_valid && cls_ready;
	assign cls_valid = (cnt_q != 2'd0);
	assign cls_data = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`RAU_ASSERT(a_cnt_range, clk, arst_n, cnt_q != 2'd3, "queue count out of range")
	`RAU_ASSERT(a_full_nopush, clk, arst_n, (cnt_q == 2'd2) |-> !push, "push into full queue")
	`RAU_ASSERT(a_ptr_sync, clk, arst_n, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (rd_ptr_q == wr_ptr_q),
		"queue pointers disagree with count")
endmodule

>>> src/rau_back.sv
// Back part: cross products, Euclidean GCD, division by GCD, range check.
// Depends on rau_pkg; the shared shift-subtract divider iterates one bit per cycle.
module rau_back import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cls_valid,
	output logic      cls_ready,
	input  cls_t      cls_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	`include "rational_arith_unit_macros.svh"

	localparam int CW = $clog2(MW + 1);

	back_state_t state_q, state_d;
	cls_t item_q;
	logic [1:0] mstep_q;
	logic [MW-1:0] p0_q, p1_q;        // products
	logic [MW:0] n_mag_q;             // raw numerator magnitude
	logic n_neg_q;
	logic [MW-1:0] d_mag_q;
	logic d_neg_q;
	logic [MW-1:0] gx_q, gy_q;        // Euclid operands
	// Shared restoring divider: quotient/dividend shift register and remainder.
	logic [MW-1:0] dq_q, drem_q, ddiv_q;
	logic [CW-1:0] dcnt_q;
	logic [MW-1:0] qn_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [WIDTH-1:0] ma, mb;
	logic [MW-1:0] prod;
	logic [MW:0] trial;
	logic [MW-1:0] rem_sh;
	logic take;
	logic ln_sign_a, ln_sign_b;

	// Multiplier operand select per step.
	always_comb begin
		ma = item_q.ln;
		mb = item_q.rd;
		case (mstep_q)
			2'd0: begin
				ma = item_q.ln;
				mb = (item_q.op == FUNC_MUL) ? item_q.rn : item_q.rd;
			end
			2'd1: begin
				ma = (item_q.op == FUNC_DIV) ? item_q.rn : item_q.rd;
				mb = item_q.ld;
			end
			2'd2: begin
				ma = item_q.rn;
				mb = item_q.ld;
			end
			default: begin
				ma = item_q.ln;
				mb = item_q.rd;
			end
		endcase
	end
	assign prod = MW'(ma) * MW'(mb);

	// One shift-subtract step.
	assign rem_sh = {drem_q[MW-2:0], dq_q[MW-1]};
	assign trial = {drem_q, dq_q[MW-1]} - {1'b0, ddiv_q};
	assign take = !trial[MW];

	assign ln_sign_a = item_q.ln_neg ^
		((item_q.op == FUNC_MUL) ? item_q.rn_neg : item_q.rd_neg);
	assign ln_sign_b = item_q.rn_neg ^ item_q.ld_neg ^ (item_q.op == FUNC_SUB);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (cls_valid) state_d = B_MUL;
			B_MUL: begin
				if (item_q.status != ST_OK) state_d = B_DONE;
				else if (mstep_q == 2'd3) state_d = B_GCD;
			end
			B_GCD: if (gy_q == '0 && dcnt_q == '0) state_d = B_DIVN;
			B_DIVN: if (dcnt_q == CW'(MW - 1)) state_d = B_DIVD;
			B_DIVD: if (dcnt_q == CW'(MW - 1)) state_d = B_DONE;
			B_DONE: if (!out_valid_q || out_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cls_ready = (state_q == B_IDLE);
	end

	logic [MW:0] sum_a, sum_b;
	logic [MW:0] nm_fin;
	logic nneg_fin, ovf;
	localparam logic [MW:0] HALF = (MW+1)'(1) << (WIDTH - 1);
	assign sum_a = {1'b0, p0_q};
	assign sum_b = {1'b0, prod};
	assign nm_fin = {1'b0, qn_q};
	assign nneg_fin = (n_neg_q != d_neg_q) && (qn_q != '0);
	assign ovf = ({1'b0, dq_q} > HALF - 1'b1) ||
		(nm_fin > (nneg_fin ? HALF : HALF - 1'b1));

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				item_q <= cls_data;
				mstep_q <= 2'd0;
				dcnt_q <= '0;
			end
			B_MUL: begin
				mstep_q <= mstep_q + 2'd1;
				case (mstep_q)
					2'd0: begin
						p0_q <= (item_q.op > FUNC_DIV) ? MW'(item_q.ln) : prod;
					end
					2'd1: begin
						d_mag_q <= (item_q.op > FUNC_DIV) ? MW'(item_q.ld) : prod;
						d_neg_q <= (item_q.op > FUNC_DIV) ? item_q.ld_neg :
							(item_q.ld_neg ^
							((item_q.op == FUNC_DIV) ? item_q.rn_neg : item_q.rd_neg));
					end
					2'd2: begin
						if (item_q.op == FUNC_ADD || item_q.op == FUNC_SUB) begin
							if (ln_sign_a == ln_sign_b) begin
								n_mag_q <= sum_a + sum_b;
								n_neg_q <= ln_sign_a;
							end else if (sum_a >= sum_b) begin
								n_mag_q <= sum_a - sum_b;
								n_neg_q <= ln_sign_a;
							end else begin
								n_mag_q <= sum_b - sum_a;
								n_neg_q <= ln_sign_b;
							end
						end else begin
							n_mag_q <= sum_a;
							n_neg_q <= (item_q.op > FUNC_DIV) ? item_q.ln_neg : ln_sign_a;
						end
					end
					default: begin
						gx_q <= n_mag_q[MW-1:0];
						gy_q <= d_mag_q;
					end
				endcase
			end
			B_GCD: begin
				// Euclid: each remainder x mod y runs through the divider.
				if (dcnt_q == '0) begin
					if (gy_q != '0) begin
						dq_q <= gx_q;
						drem_q <= '0;
						ddiv_q <= gy_q;
						dcnt_q <= CW'(1);
					end else begin
						dq_q <= n_mag_q[MW-1:0];
						drem_q <= '0;
						ddiv_q <= gx_q;
					end
				end else begin
					drem_q <= take ? trial[MW-1:0] : rem_sh;
					dq_q <= {dq_q[MW-2:0], take};
					if (dcnt_q == CW'(MW)) begin
						gx_q <= gy_q;
						gy_q <= take ? trial[MW-1:0] : rem_sh;
						dcnt_q <= '0;
					end else begin
						dcnt_q <= dcnt_q + CW'(1);
					end
				end
			end
			B_DIVN, B_DIVD: begin
				if (dcnt_q == CW'(MW - 1)) begin
					dcnt_q <= '0;
					if (state_q == B_DIVN) begin
						qn_q <= {dq_q[MW-2:0], take};
						dq_q <= d_mag_q;
						drem_q <= '0;
					end else begin
						dq_q <= {dq_q[MW-2:0], take};
						drem_q <= take ? trial[MW-1:0] : rem_sh;
					end
				end else begin
					dcnt_q <= dcnt_q + CW'(1);
					dq_q <= {dq_q[MW-2:0], take};
					drem_q <= take ? trial[MW-1:0] : rem_sh;
				end
			end
			default: begin
			end
		endcase
	end

	// The divider counter is zero on entry to DIVN and DIVD, so each division
	// takes MW steps, counted from 0 to MW-1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DONE && (!out_valid_q || out_ready)) begin
			if (item_q.status != ST_OK) begin
				out_q.res_num <= '0;
				out_q.res_den <= 31'd1;
				out_q.status <= item_q.status;
			end else if (ovf) begin
				out_q.res_num <= '0;
				out_q.res_den <= 31'd1;
				out_q.status <= ST_OVF;
			end else begin
				out_q.status <= ST_OK;
				out_q.res_num <= 32'(signed'(nneg_fin ?
					(~qn_q[WIDTH-1:0] + 1'b1) : qn_q[WIDTH-1:0]));
				out_q.res_den <= 31'(dq_q[WIDTH-2:0]);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`RAU_ASSERT(a_hold, clk, arst_n, (out_valid && !out_ready) |=> $stable(out_data),
		"result changed while stalled")
	`RAU_ASSERT(a_den_pos, clk, arst_n, out_valid |-> (out_data.res_den != '0),
		"zero result denominator")
	`RAU_ASSERT(a_err_zero, clk, arst_n,
		(out_valid && out_data.status != ST_OK) |-> (out_data.res_num == '0),
		"error result with nonzero numerator")
	`RAU_ASSERT_NR(a_accept_idle, clk, (cls_valid && cls_ready) |-> (state_q == B_IDLE),
		"accept outside idle")
endmodule

>>> dv/rational_arith_unit_tb.sv
// Self-checking testbench for rational_arith_unit: directed and random fraction operations.
// Depends on rau_pkg and the rational_arith_unit RTL; expected results come from a local model.
module rational_arith_unit_tb;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FUNC_RED = 3'd4;
	localparam int DRAIN_CYCLES = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	out_item_t pending_fracs[$];
	int        errors = 0;
	bit        calm = 1'b0;
	int        rx_hold_cycles = 0;

	rational_arith_unit dut (.*);

	always #6 clk = ~clk;

	// Signed value split into a sign and a magnitude, as the block works on it.
	function automatic void split(input logic [31:0] raw, output bit ng, output logic [63:0] mg);
		logic [63:0] mask, v;
		mask = (64'd1 << WIDTH) - 64'd1;
		v = {32'd0, raw} & mask;
		ng = v[WIDTH-1];
		mg = ng ? ((~v + 64'd1) & mask) : v;
	endfunction

	function automatic void smul(input bit an, input logic [63:0] am, input bit bn,
			input logic [63:0] bm, output bit rn, output logic [63:0] rm);
		rm = am * bm;
		rn = (an != bn) && (rm != 0);
	endfunction

	function automatic void sadd(input bit an, input logic [63:0] am, input bit bn,
			input logic [63:0] bm, output bit rn, output logic [63:0] rm);
		if (an == bn) begin
			rm = am + bm;
			rn = an;
		end else if (am >= bm) begin
			rm = am - bm;
			rn = an;
		end else begin
			rm = bm - am;
			rn = bn;
		end
		if (rm == 0)
			rn = 1'b0;
	endfunction

	function automatic out_item_t reduce_fraction(in_item_t it);
		out_item_t r;
		bit lnn, ldn, rnn, rdn, nn, dn, t1n, t2n;
		logic [63:0] lnm, ldm, rnm, rdm, nm, dm, t1m, t2m, g, x, y, t, half;
		bit two;
		split(it.lhs_num, lnn, lnm);
		split(it.lhs_den, ldn, ldm);
		split(it.rhs_num, rnn, rnm);
		split(it.rhs_den, rdn, rdm);
		two = it.func <= FUNC_DIV;
		half = 64'd1 << (WIDTH - 1);
		r.res_num = '0;
		r.res_den = 31'd1;
		r.status = ST_OK;
		if (ldm == 0 || (two && rdm == 0)) begin
			r.status = ST_ZDEN;
			return r;
		end
		if (it.func == FUNC_DIV && rnm == 0) begin
			r.status = ST_DIVZ;
			return r;
		end
		case (it.func)
			FUNC_ADD, FUNC_SUB: begin
				smul(lnn, lnm, rdn, rdm, t1n, t1m);
				smul(rnn, rnm, ldn, ldm, t2n, t2m);
				if (it.func == FUNC_SUB)
					t2n = !t2n && t2m != 0;
				sadd(t1n, t1m, t2n, t2m, nn, nm);
				smul(ldn, ldm, rdn, rdm, dn, dm);
			end
			FUNC_MUL: begin
				smul(lnn, lnm, rnn, rnm, nn, nm);
				smul(ldn, ldm, rdn, rdm, dn, dm);
			end
			FUNC_DIV: begin
				smul(lnn, lnm, rdn, rdm, nn, nm);
				smul(ldn, ldm, rnn, rnm, dn, dm);
			end
			default: begin
				nn = lnn; nm = lnm;
				dn = ldn; dm = ldm;
			end
		endcase
		x = nm;
		y = dm;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		g = x;
		nm = nm / g;
		dm = dm / g;
		nn = (nn != dn) && nm != 0;
		if (dm > half - 64'd1 || nm > (nn ? half : half - 64'd1)) begin
			r.status = ST_OVF;
			return r;
		end
		t = nn ? (~nm + 64'd1) : nm;
		r.res_num = t[31:0];
		r.res_den = dm[30:0];
		return r;
	endfunction

	task automatic send_item(in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		pending_fracs.push_back(reduce_fraction(it));
		if (!calm && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end
	endtask

	task automatic send_op(logic [2:0] f, int ln, int ld, int rn, int rd);
		in_item_t it;
		it.func = f;
		it.lhs_num = ln;
		it.lhs_den = ld;
		it.rhs_num = rn;
		it.rhs_den = rd;
		send_item(it);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_fracs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, 200) - 100;
			5, 6: return $urandom;
			7: case ($urandom_range(0, 4))
				0: return 32'd0;
				1: return 32'd1;
				2: return 32'hffff_ffff;
				3: return 32'h7fff_ffff;
				default: return 32'h8000_0000;
			endcase
			8: return ($urandom_range(1, 9) << $urandom_range(0, 28)) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic test_directed();
		send_op(FUNC_ADD, 1, 2, 1, 3);
		send_op(FUNC_SUB, 1, 2, 1, 2);
		send_op(FUNC_MUL, -3, 4, 8, -9);
		send_op(FUNC_DIV, 5, 7, -10, 21);
		send_op(FUNC_RED, 12, -18, 99, 0);
		send_op(3'd5, 0, -7, 1, 1);
		send_op(3'd6, 32'h8000_0000, -1, 0, 0);
		send_op(3'd7, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
		send_op(FUNC_ADD, 1, 0, 1, 1);
		send_op(FUNC_MUL, 1, 1, 1, 0);
		send_op(FUNC_RED, 1, 0, 1, 1);
		send_op(FUNC_DIV, 1, 1, 0, 5);
		send_op(FUNC_DIV, 1, 0, 0, 5);
		send_op(FUNC_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		send_op(FUNC_MUL, 32'h8000_0000, 1, 1, 1);
		send_op(FUNC_MUL, 32'h8000_0000, 1, -1, 1);
		send_op(FUNC_DIV, 1, 32'h8000_0000, 1, 1);
		send_op(FUNC_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		send_op(FUNC_SUB, 32'h8000_0000, 1, 1, 1);
		send_op(FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(FUNC_SUB, 0, 5, 0, -3);
		send_op(FUNC_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_op(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	task automatic test_random(int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it.func = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 4));
			it.lhs_num = pick_value();
			it.lhs_den = pick_value();
			it.rhs_num = pick_value();
			it.rhs_den = pick_value();
			send_item(it);
		end
	endtask

	// The receiver stops for a long stretch while items keep coming, so the input stalls.
	task automatic test_backpressure();
		rx_hold_cycles = 3000;
		test_random(10);
		wait_idle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		wait_idle();
		test_random(500);
		test_backpressure();
		test_random(400);
		wait_idle();
		calm = 1'b1;
		test_random(200);
		wait_idle();
		if (errors == 0)
			$display("rational_arith_unit_tb OK");
		else
			$display("rational_arith_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000_000;
		$display("rational_arith_unit_tb NOT OK");
		$finish;
	end

	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				rx_hold_cycles--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				burst = $urandom_range(1, 11);
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fracs.size() == 0) begin
				$display("%t unexpected transfer: actual %0d/%0d status %0d", $realtime,
					out_data.res_num, out_data.res_den, out_data.status);
				errors++;
			end else begin
				want = pending_fracs.pop_front();
				if (out_data.res_num !== want.res_num) begin
					$display("%t res_num expected %0d actual %0d", $realtime,
						want.res_num, out_data.res_num);
					errors++;
				end
				if (out_data.res_den !== want.res_den) begin
					$display("%t res_den expected %0d actual %0d", $realtime,
						want.res_den, out_data.res_den);
					errors++;
				end
				if (out_data.status !== want.status) begin
					$display("%t status expected %0d actual %0d", $realtime,
						want.status, out_data.status);
					errors++;
				end
			end
		end
	end
endmodule
